@@ src/b2ssw_pkg.sv @@
// shared constants, types and functions for the binary to seven-segment word block
// no dependencies

package b2ssw_pkg;

    localparam int DIGIT_COUNT_DEFAULT = 8;
    localparam int MaxDigits           = 10;
    localparam int ValueWidth          = 31;
    localparam int AddrWidth           = 4;
    localparam int SegWidth            = 8;
    localparam int BcdWidth            = 4 * MaxDigits;
    localparam int DabbleBits          = 32;
    localparam int StepsPerStage       = 4;
    localparam int DabbleStages        = DabbleBits / StepsPerStage;

    localparam logic [SegWidth-1:0] SegBlank      = 8'h00;
    localparam logic [SegWidth-1:0] SegUnderscore = 8'h08;

    typedef struct packed {
        logic [BcdWidth-1:0]   bcd;
        logic [DabbleBits-1:0] bin;
    } dabble_t;

    // dp=bit7, a=bit6 down to g=bit0
    function automatic logic [SegWidth-1:0] seg_glyph(input logic [3:0] digit);
        logic [SegWidth-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h7E;
            4'd1:    pat = 8'h30;
            4'd2:    pat = 8'h6D;
            4'd3:    pat = 8'h79;
            4'd4:    pat = 8'h33;
            4'd5:    pat = 8'h5B;
            4'd6:    pat = 8'h5F;
            4'd7:    pat = 8'h70;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h7B;
            default: pat = SegUnderscore;
        endcase
        return pat;
    endfunction

    // several shift-and-add-3 steps of the double dabble conversion
    function automatic dabble_t dabble_chunk(input dabble_t x);
        dabble_t             y;
        logic [BcdWidth-1:0] adj;
        y = x;
        for (int s = 0; s < StepsPerStage; s++) begin
            for (int d = 0; d < MaxDigits; d++) begin
                adj[4*d +: 4] = (y.bcd[4*d +: 4] >= 4'd5) ?
                                4'(y.bcd[4*d +: 4] + 4'd3) : y.bcd[4*d +: 4];
            end
            y.bcd = {adj[BcdWidth-2:0], y.bin[DabbleBits-1]};
            y.bin = {y.bin[DabbleBits-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

@@ src/b2ssw_dabble_pipe.sv @@
// pipelined binary to bcd conversion followed by a glyph and blanking stage
// depends on b2ssw_pkg

module b2ssw_dabble_pipe #(
    parameter int DIGIT_COUNT = b2ssw_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [b2ssw_pkg::ValueWidth-1:0]       in_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [DIGIT_COUNT-1:0][b2ssw_pkg::SegWidth-1:0] out_pats
);

    localparam int Stages = b2ssw_pkg::DabbleStages;

    b2ssw_pkg::dabble_t data_reg [Stages];
    logic [Stages-1:0]  valid_reg;
    logic [Stages-1:0]  take;
    b2ssw_pkg::dabble_t first_in;

    logic                                           gvalid_reg;
    logic                                           gtake;
    logic [DIGIT_COUNT-1:0][b2ssw_pkg::SegWidth-1:0] pats_reg;
    logic [DIGIT_COUNT-1:0][b2ssw_pkg::SegWidth-1:0] pats_next;

    assign first_in.bcd = '0;
    assign first_in.bin = {{(b2ssw_pkg::DabbleBits - b2ssw_pkg::ValueWidth){1'b0}}, in_value};

    assign gtake    = !gvalid_reg || out_ready;
    assign in_ready = take[0];

    genvar k;
    generate
        for (k = 0; k < Stages; k++) begin : g_stage
            if (k == Stages - 1) begin : g_tail
                assign take[k] = !valid_reg[k] || gtake;
            end else begin : g_mid
                assign take[k] = !valid_reg[k] || take[k+1];
            end

            if (k == 0) begin : g_first
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        valid_reg[k] <= 1'b0;
                    end else if (take[k]) begin
                        valid_reg[k] <= in_valid;
                    end
                end
                always_ff @(posedge aclk) begin
                    if (take[k]) begin
                        data_reg[k] <= b2ssw_pkg::dabble_chunk(first_in);
                    end
                end
            end else begin : g_next
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        valid_reg[k] <= 1'b0;
                    end else if (take[k]) begin
                        valid_reg[k] <= valid_reg[k-1];
                    end
                end
                always_ff @(posedge aclk) begin
                    if (take[k]) begin
                        data_reg[k] <= b2ssw_pkg::dabble_chunk(data_reg[k-1]);
                    end
                end
            end
        end
    endgenerate

    // leading zeros blank down to, but not including, the least significant place
    always_comb begin
        logic       lead;
        logic [3:0] digit;
        lead = 1'b1;
        for (int p = DIGIT_COUNT - 1; p >= 0; p--) begin
            digit = data_reg[Stages-1].bcd[4*p +: 4];
            lead  = lead && (digit == 4'd0);
            pats_next[p] = (lead && p != 0) ? b2ssw_pkg::SegBlank
                                            : b2ssw_pkg::seg_glyph(digit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gvalid_reg <= 1'b0;
        end else if (gtake) begin
            gvalid_reg <= valid_reg[Stages-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (gtake) begin
            pats_reg <= pats_next;
        end
    end

    assign out_valid = gvalid_reg;
    assign out_pats  = pats_reg;

endmodule

@@ src/b2ssw_serializer.sv @@
// holds one converted value and sends its digit patterns as words, msb place first
// depends on b2ssw_pkg

module b2ssw_serializer #(
    parameter int DIGIT_COUNT = b2ssw_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [DIGIT_COUNT-1:0][b2ssw_pkg::SegWidth-1:0] in_pats,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [b2ssw_pkg::AddrWidth-1:0]        m_digit_address,
    output logic [b2ssw_pkg::SegWidth-1:0]         m_segments,
    output logic                                   m_last
);

    localparam logic [b2ssw_pkg::AddrWidth-1:0] FirstAddr = b2ssw_pkg::AddrWidth'(DIGIT_COUNT);
    localparam logic [b2ssw_pkg::AddrWidth-1:0] LastAddr  = b2ssw_pkg::AddrWidth'(1);

    logic                                            busy_reg;
    logic [b2ssw_pkg::AddrWidth-1:0]                 addr_reg;
    logic [DIGIT_COUNT-1:0][b2ssw_pkg::SegWidth-1:0] pats_reg;
    logic                                            is_last;
    logic                                            load;

    assign is_last  = (addr_reg == LastAddr);
    assign in_ready = !busy_reg || (m_ready && is_last);
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && m_ready && is_last) begin
            busy_reg <= 1'b0;
        end
    end

    // the word on the port is always the top place of the shift line
    always_ff @(posedge aclk) begin
        if (load) begin
            addr_reg <= FirstAddr;
            pats_reg <= in_pats;
        end else if (busy_reg && m_ready && !is_last) begin
            addr_reg <= addr_reg - LastAddr;
            for (int p = DIGIT_COUNT - 1; p >= 1; p--) begin
                pats_reg[p] <= pats_reg[p-1];
            end
        end
    end

    assign m_valid         = busy_reg;
    assign m_digit_address = addr_reg;
    assign m_segments      = pats_reg[DIGIT_COUNT-1];
    assign m_last          = is_last;

    a_addr_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_address != '0 && m_digit_address <= FirstAddr))
        else $error("digit address out of range");

    a_addr_step : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=>
            (m_valid && m_digit_address == $past(m_digit_address) - LastAddr))
        else $error("digit address did not step down");

    a_last_lit : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_segments != b2ssw_pkg::SegBlank))
        else $error("least significant place blanked");

    a_new_starts_top : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (m_valid && m_digit_address == FirstAddr))
        else $error("new value does not start at the top place");

endmodule

@@ src/binary_to_seven_segment_words_top.sv @@
// Converts a 31-bit unsigned value into DIGIT_COUNT display words, one per decimal
// place, most significant first (address DIGIT_COUNT) down to address 1, which is
// flagged by m_last. Patterns are no-decode seven-segment codes (bit7 dot, bit6 a
// .. bit0 g) with leading zeros blanked; zero still shows a single 0. Digits above
// DIGIT_COUNT places are dropped. Conversion is a nine-stage pipeline (eight double
// dabble stages of four bits each, then a glyph and blanking stage). The output
// serializer sends one word per cycle while m_ready is high, and it takes the next
// value as the last word of the current one is taken; up to nine further values
// queue in the pipeline while it sends.
// depends on b2ssw_pkg, b2ssw_dabble_pipe, b2ssw_serializer

module binary_to_seven_segment_words_top #(
    parameter int DIGIT_COUNT = b2ssw_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [b2ssw_pkg::ValueWidth-1:0]    s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [b2ssw_pkg::AddrWidth-1:0]     m_digit_address,
    output logic [b2ssw_pkg::SegWidth-1:0]      m_segments,
    output logic                                m_last
);

    logic                                            pats_valid;
    logic                                            pats_ready;
    logic [DIGIT_COUNT-1:0][b2ssw_pkg::SegWidth-1:0] pats;

    b2ssw_dabble_pipe #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (pats_valid),
        .out_ready (pats_ready),
        .out_pats  (pats)
    );

    b2ssw_serializer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_ser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (pats_valid),
        .in_ready        (pats_ready),
        .in_pats         (pats),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digit_address (m_digit_address),
        .m_segments      (m_segments),
        .m_last          (m_last)
    );

endmodule

@@ tb/binary_to_seven_segment_words_top_tb.sv @@
// testbench for binary_to_seven_segment_words_top: values in, eight digit words out per value
// checks every word against an in-bench digit splitter and blanking predictor
// depends on b2ssw_pkg and binary_to_seven_segment_words_top
`timescale 1ns / 100ps

module binary_to_seven_segment_words_top_tb;

    localparam int          DIGITS       = 8;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          REPORT_MAX   = 10;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [30:0] VALUE_MAX    = 31'h7FFF_FFFF;

    // no-decode patterns, dot on bit7, a on bit6 down to g on bit0
    localparam logic [b2ssw_pkg::SegWidth-1:0] GLYPHS [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    typedef struct {
        logic [b2ssw_pkg::AddrWidth-1:0] addr;
        logic [b2ssw_pkg::SegWidth-1:0]  seg;
        logic                            last;
    } digit_word_t;

    logic                             aclk    = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [b2ssw_pkg::ValueWidth-1:0] s_value = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [b2ssw_pkg::AddrWidth-1:0]  m_digit_address;
    logic [b2ssw_pkg::SegWidth-1:0]   m_segments;
    logic                             m_last;

    digit_word_t pending_words [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_req_count = 0;

    binary_to_seven_segment_words_top #(
        .DIGIT_COUNT(DIGITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digit_address (m_digit_address),
        .m_segments      (m_segments),
        .m_last          (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("binary_to_seven_segment_words_top verification failed");
            $finish;
        end
    end

    // split into low decimal places, blank leading zeros, queue one word per place
    function automatic void predict_digit_words(
        input logic [b2ssw_pkg::ValueWidth-1:0] value
    );
        logic [b2ssw_pkg::SegWidth-1:0] pats [DIGITS];
        int unsigned                    rem;
        bit                             leading;
        digit_word_t                    w;
        rem = 32'(value);
        for (int i = DIGITS - 1; i >= 0; i--) begin
            pats[i] = GLYPHS[rem % 10];
            rem     = rem / 10;
        end
        leading = 1'b1;
        for (int i = 0; i < DIGITS - 1; i++) begin
            if (leading && pats[i] == GLYPHS[0]) begin
                pats[i] = b2ssw_pkg::SegBlank;
            end else begin
                leading = 1'b0;
            end
        end
        for (int i = 0; i < DIGITS; i++) begin
            w.addr = b2ssw_pkg::AddrWidth'(DIGITS - i);
            w.seg  = pats[i];
            w.last = (i == DIGITS - 1);
            pending_words.push_back(w);
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0d] mismatch: %s", cycle_count, msg);
        end
    endfunction

    // receiver: random stalls, or a long hold-off counted down here
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req_count != hold_seen) begin
                hold_seen = hold_req_count;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        digit_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                note_mismatch($sformatf("unexpected word addr=%0d seg=%02h last=%0b",
                                        m_digit_address, m_segments, m_last));
            end else begin
                want = pending_words.pop_front();
                if (m_digit_address !== want.addr) begin
                    note_mismatch($sformatf("digit_address exp %0d got %0d",
                                            want.addr, m_digit_address));
                end
                if (m_segments !== want.seg) begin
                    note_mismatch($sformatf("segments exp %02h got %02h addr %0d",
                                            want.seg, m_segments, want.addr));
                end
                if (m_last !== want.last) begin
                    note_mismatch($sformatf("last exp %0b got %0b addr %0d",
                                            want.last, m_last, want.addr));
                end
            end
        end
    end

    // called just after a rising edge; returns right after the edge that takes the word
    task automatic send_value(input logic [b2ssw_pkg::ValueWidth-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_digit_words(value);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [b2ssw_pkg::ValueWidth-1:0] random_value();
        longint unsigned                  power;
        logic [b2ssw_pkg::ValueWidth-1:0] v;
        power = 1;
        case ($urandom_range(3))
            0: v = b2ssw_pkg::ValueWidth'($urandom & VALUE_MAX);
            1: v = b2ssw_pkg::ValueWidth'($urandom_range(0, 99999999));
            2: v = b2ssw_pkg::ValueWidth'($urandom_range(0, 999));
            default: begin
                // one nonzero digit among zeros, masked to VALUE_MAX, which breaks the pattern for the largest products
                repeat ($urandom_range(0, 9)) power = power * 10;
                v = b2ssw_pkg::ValueWidth'(($urandom_range(1, 9) * power) & VALUE_MAX);
            end
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [b2ssw_pkg::ValueWidth-1:0] values [20] = '{
            31'd0, 31'd1, 31'd9, 31'd10, 31'd100, 31'd12345678, 31'd87654321,
            31'd99999999, 31'd100000000, 31'd100000007, 31'd10000000, 31'd90909090,
            31'd1000001, 31'd5, 31'd2147483647, 31'h4000_0000, 31'h5555_5555,
            31'h2AAA_AAAA, 31'd1999999999, 31'd20000000
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (values[i]) send_value(values[i]);
        wait_for_drain();
    endtask

    task automatic test_random_phase(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_value(random_value());
        wait_for_drain();
    endtask

    // long receiver hold-off while words keep coming, so the pipeline fills and stalls input
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_count++;
        repeat (16) send_value(random_value());
        wait_for_drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phase(20, 8, 45);
        test_random_phase(20, 45, 8);
        test_output_backpressure();
        test_random_phase(20, 0, 0);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("binary_to_seven_segment_words_top verification clean");
        end else begin
            $display("binary_to_seven_segment_words_top verification failed");
        end
        $finish;
    end

endmodule
